/* design/knl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knl_pkg
// Shared types, character codes and keyword tables for the keyword and
// number lexer.
// ----------------------------------------------------------------------------
package knl_pkg;

  // Counter widths
  localparam int POS_WIDTH_DEF  = 24;
  localparam int LINE_WIDTH_DEF = 24;
  localparam int LEN_WIDTH_DEF  = 16;

  // Result runs held between the scanner and the token port
  localparam int RUN_DEPTH = 2;
  localparam int RUN_MAX   = 3;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_byte;
    logic       end_of_source;
  } src_item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [1:0]  error_code;
    logic [7:0]  bad_char;
    logic [23:0] start_pos;
    logic [23:0] line_number;
    logic [15:0] token_length;
    logic        last_of_run;
  } tok_item_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_NUM     = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_PCT     = 3'd4,
    MODE_GT      = 3'd5,
    MODE_HALT    = 3'd6
  } scan_mode_t;

  // Token kinds
  localparam logic [2:0] KIND_IDENT    = 3'd0;
  localparam logic [2:0] KIND_INT      = 3'd1;
  localparam logic [2:0] KIND_FLOAT    = 3'd2;
  localparam logic [2:0] KIND_SLONIK   = 3'd3;
  localparam logic [2:0] KIND_FROM     = 3'd4;
  localparam logic [2:0] KIND_KARTOHKA = 3'd5;
  localparam logic [2:0] KIND_OUTPUT   = 3'd6;
  localparam logic [2:0] KIND_END      = 3'd7;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_EXTRA_DOT = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN = 2'd2;

  // Character codes
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  // Keyword spellings, zero padded to eight characters
  localparam logic [7:0] KW_TEXT [3][8] = '{
    '{"s", "l", "o", "n", "i", "k", 8'h00, 8'h00},
    '{"f", "r", "o", "m", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"k", "a", "r", "t", "o", "h", "k", "a"}
  };
  localparam logic [3:0] KW_LEN [3] = '{4'd6, 4'd4, 4'd8};
  localparam logic [2:0] KW_KIND [3] = '{KIND_SLONIK, KIND_FROM, KIND_KARTOHKA};

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

endpackage

/* design/keyword_number_lexer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_number_lexer_unit
// Streaming lexer: one source byte per transaction in, tokens with kind,
// start offset, line and length out, with keyword, number and comment rules.
// ----------------------------------------------------------------------------
// Latency: the results of an item appear on the token port the cycle after
//   it is accepted, once the results of earlier items have drained.
// Throughput: one item per cycle unless the source port stalls; an item that causes
//   k results takes k token port transactions, and a two-run result queue decouples
//   the sides. The source port stalls while the queue holds two runs.
// Reset: synchronous; scanner returns to idle at offset 0, line 1, and the
//   result queue empties.
module keyword_number_lexer_unit #(
  parameter int POS_WIDTH  = knl_pkg::POS_WIDTH_DEF,
  parameter int LINE_WIDTH = knl_pkg::LINE_WIDTH_DEF,
  parameter int LEN_WIDTH  = knl_pkg::LEN_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  input  knl_pkg::src_item_t src_data,
  output logic              tok_valid,
  input  logic              tok_stall,
  output knl_pkg::tok_item_t tok_data
);
  import knl_pkg::*;

  localparam int PTR_W = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int FILL_W = $clog2(RUN_DEPTH + 1);

  // Scanner state
  scan_mode_t            mode, mode_next;
  logic [POS_WIDTH-1:0]  byte_pos, byte_pos_next;
  logic [LINE_WIDTH-1:0] line, line_next;
  logic [POS_WIDTH-1:0]  tok_start, tok_start_next;
  logic [LEN_WIDTH-1:0]  tok_len, tok_len_next;
  logic                  seen_dot, seen_dot_next;
  logic [2:0]            kw_hits, kw_hits_next;

  // Results of the current item
  tok_item_t [RUN_MAX-1:0] step_res;
  logic [1:0]              step_cnt;

  // Result queue, one run of up to three results per entry
  tok_item_t [RUN_MAX-1:0] run_res [RUN_DEPTH];
  logic [1:0]              run_cnt [RUN_DEPTH];
  logic [PTR_W-1:0]        wr_ptr, rd_ptr;
  logic [FILL_W-1:0]       fill;
  logic [1:0]              sub;

  logic src_acc, push, pop, run_done;

  function automatic tok_item_t mk_res(
    input logic [2:0]            kind,
    input logic [1:0]            err,
    input logic [7:0]            bad,
    input logic [POS_WIDTH-1:0]  pos,
    input logic [LINE_WIDTH-1:0] ln,
    input logic [LEN_WIDTH-1:0]  len
  );
    tok_item_t                r;
    logic [POS_WIDTH+23:0]    pos_ext;
    logic [LINE_WIDTH+23:0]   line_ext;
    logic [LEN_WIDTH+15:0]    len_ext;
    pos_ext  = {24'd0, pos};
    line_ext = {24'd0, ln};
    len_ext  = {16'd0, len};
    r.token_kind   = kind;
    r.error_code   = err;
    r.bad_char     = bad;
    r.start_pos    = pos_ext[23:0];
    r.line_number  = line_ext[23:0];
    r.token_length = len_ext[15:0];
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  // Token flushed from the state in progress
  function automatic logic pend_ok(input scan_mode_t m);
    return (m == MODE_IDENT) || (m == MODE_NUM) || (m == MODE_PCT) || (m == MODE_GT);
  endfunction

  function automatic tok_item_t pend_res(
    input scan_mode_t            m,
    input logic [2:0]            hits,
    input logic                  dot,
    input logic [POS_WIDTH-1:0]  start,
    input logic [LINE_WIDTH-1:0] ln,
    input logic [LEN_WIDTH-1:0]  len
  );
    tok_item_t  r;
    logic [2:0] kind;
    kind = KIND_IDENT;
    for (int k = 0; k < 3; k++) begin
      if (hits[k] && (len == LEN_WIDTH'(KW_LEN[k]))) begin
        kind = KW_KIND[k];
      end
    end
    unique case (m)
      MODE_IDENT: r = mk_res(kind, ERR_NONE, 8'd0, start, ln, len);
      MODE_NUM:   r = mk_res(dot ? KIND_FLOAT : KIND_INT, ERR_NONE, 8'd0, start, ln, len);
      MODE_PCT:   r = mk_res(KIND_IDENT, ERR_UNKNOWN, CH_PERCENT, start, ln, '0);
      default:    r = mk_res(KIND_IDENT, ERR_UNKNOWN, CH_GT, start, ln, '0);
    endcase
    return r;
  endfunction

  function automatic logic [2:0] hits_step(
    input logic [2:0]           hits,
    input logic [LEN_WIDTH-1:0] len,
    input logic [7:0]           c
  );
    logic [2:0] h;
    h = hits;
    for (int k = 0; k < 3; k++) begin
      if (!((len < LEN_WIDTH'(KW_LEN[k])) && (KW_TEXT[k][len[2:0]] == c))) begin
        h[k] = 1'b0;
      end
    end
    return h;
  endfunction

  assign src_acc   = src_valid && !src_stall;
  assign src_stall = (fill == FILL_W'(RUN_DEPTH));

  // Scanner next state and the results of one item
  always_comb begin
    logic [7:0] c;
    logic       do_idle;
    c              = src_data.char_byte;
    do_idle        = 1'b0;
    mode_next      = mode;
    byte_pos_next  = byte_pos;
    line_next      = line;
    tok_start_next = tok_start;
    tok_len_next   = tok_len;
    seen_dot_next  = seen_dot;
    kw_hits_next   = kw_hits;
    step_res       = '0;
    step_cnt       = 2'd0;

    if (src_data.has_byte) begin
      unique case (mode)
        MODE_HALT: begin
        end
        MODE_COMMENT: begin
          do_idle = (c == CH_NEWLINE);
        end
        MODE_PCT: begin
          if (c == CH_PERCENT) begin
            mode_next = MODE_COMMENT;
          end else begin
            step_res[step_cnt] = pend_res(mode, kw_hits, seen_dot, tok_start, line, tok_len);
            step_cnt = step_cnt + 2'd1;
            mode_next = MODE_HALT;
          end
        end
        MODE_GT: begin
          if (c == CH_GT) begin
            step_res[step_cnt] = mk_res(KIND_OUTPUT, ERR_NONE, 8'd0, tok_start, line,
                                        LEN_WIDTH'(2));
            step_cnt = step_cnt + 2'd1;
            mode_next = MODE_IDLE;
          end else begin
            step_res[step_cnt] = pend_res(mode, kw_hits, seen_dot, tok_start, line, tok_len);
            step_cnt = step_cnt + 2'd1;
            mode_next = MODE_HALT;
          end
        end
        MODE_IDENT: begin
          if (is_alpha(c) || is_digit(c) || (c == CH_UNDER)) begin
            kw_hits_next = hits_step(kw_hits, tok_len, c);
            tok_len_next = (&tok_len) ? tok_len : tok_len + LEN_WIDTH'(1);
          end else begin
            step_res[step_cnt] = pend_res(mode, kw_hits, seen_dot, tok_start, line, tok_len);
            step_cnt = step_cnt + 2'd1;
            do_idle = 1'b1;
          end
        end
        MODE_NUM: begin
          if (is_digit(c)) begin
            tok_len_next = (&tok_len) ? tok_len : tok_len + LEN_WIDTH'(1);
          end else if (c == CH_DOT) begin
            if (seen_dot) begin
              // Drop the number, flag the second dot
              step_res[step_cnt] = mk_res(KIND_IDENT, ERR_EXTRA_DOT, 8'd0, byte_pos, line,
                                          '0);
              step_cnt = step_cnt + 2'd1;
              mode_next = MODE_HALT;
            end else begin
              seen_dot_next = 1'b1;
              tok_len_next  = (&tok_len) ? tok_len : tok_len + LEN_WIDTH'(1);
            end
          end else begin
            step_res[step_cnt] = pend_res(mode, kw_hits, seen_dot, tok_start, line, tok_len);
            step_cnt = step_cnt + 2'd1;
            do_idle = 1'b1;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      if (do_idle) begin
        mode_next = MODE_IDLE;
        if ((c == CH_SPACE) || (c == CH_TAB)) begin
        end else if (c == CH_NEWLINE) begin
          line_next = (&line) ? line : line + LINE_WIDTH'(1);
        end else begin
          tok_start_next = byte_pos;
          if (c == CH_PERCENT) begin
            mode_next = MODE_PCT;
          end else if (c == CH_GT) begin
            mode_next = MODE_GT;
          end else if (is_alpha(c) || (c == CH_UNDER)) begin
            kw_hits_next = hits_step(3'b111, '0, c);
            tok_len_next = LEN_WIDTH'(1);
            mode_next    = MODE_IDENT;
          end else if (is_digit(c)) begin
            tok_len_next  = LEN_WIDTH'(1);
            seen_dot_next = 1'b0;
            mode_next     = MODE_NUM;
          end else begin
            step_res[step_cnt] = mk_res(KIND_IDENT, ERR_UNKNOWN, c, byte_pos, line, '0);
            step_cnt = step_cnt + 2'd1;
            mode_next = MODE_HALT;
          end
        end
      end

      byte_pos_next = (&byte_pos) ? byte_pos : byte_pos + POS_WIDTH'(1);
    end

    if (src_data.end_of_source) begin
      // Flush, mark the end, then start over for the next source
      if (pend_ok(mode_next)) begin
        step_res[step_cnt] = pend_res(mode_next, kw_hits_next, seen_dot_next, tok_start_next,
                                      line_next, tok_len_next);
        step_cnt = step_cnt + 2'd1;
      end
      step_res[step_cnt] = mk_res(KIND_END, ERR_NONE, 8'd0, byte_pos_next, line_next, '0);
      step_cnt = step_cnt + 2'd1;
      mode_next      = MODE_IDLE;
      byte_pos_next  = '0;
      line_next      = LINE_WIDTH'(1);
      tok_start_next = '0;
      tok_len_next   = '0;
      seen_dot_next  = 1'b0;
      kw_hits_next   = 3'b111;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      byte_pos  <= '0;
      line      <= LINE_WIDTH'(1);
      tok_start <= '0;
      tok_len   <= '0;
      seen_dot  <= 1'b0;
      kw_hits   <= 3'b111;
    end else if (src_acc) begin
      mode      <= mode_next;
      byte_pos  <= byte_pos_next;
      line      <= line_next;
      tok_start <= tok_start_next;
      tok_len   <= tok_len_next;
      seen_dot  <= seen_dot_next;
      kw_hits   <= kw_hits_next;
    end
  end

  // Result queue
  assign push      = src_acc && (step_cnt != 2'd0);
  assign tok_valid = (fill != '0);
  assign pop       = tok_valid && !tok_stall;
  assign run_done  = pop && (sub == (run_cnt[rd_ptr] - 2'd1));

  always_comb begin
    tok_data             = run_res[rd_ptr][sub];
    tok_data.last_of_run = (sub == (run_cnt[rd_ptr] - 2'd1));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      run_res[wr_ptr] <= step_res;
      run_cnt[wr_ptr] <= step_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      sub    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(RUN_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (run_done) begin
        rd_ptr <= (rd_ptr == PTR_W'(RUN_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
        sub    <= 2'd0;
      end else if (pop) begin
        sub <= sub + 2'd1;
      end
      fill <= fill + FILL_W'(push) - FILL_W'(run_done);
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(RUN_DEPTH))
    else $error("result queue over its depth");

  a_head_run: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> ((run_cnt[rd_ptr] != 2'd0) && (sub < run_cnt[rd_ptr])))
    else $error("token port reads past its run");

  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    (src_acc && (mode == MODE_HALT) && !src_data.end_of_source) |-> (step_cnt == 2'd0))
    else $error("halted scanner produced a result");

  a_eos_idle: assert property (@(posedge clk) disable iff (rst)
    (src_acc && src_data.end_of_source) |=> ((mode == MODE_IDLE) && (byte_pos == '0)))
    else $error("scanner not back at reset state after end of source");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyword and number lexer. Short sources and
// random token streams are driven over the valid/stall source port. A
// built-in lexer predicts every token, error and end marker, and the token
// port is checked transaction by transaction, with random gaps and stalls on
// both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import knl_pkg::*;

  logic       clk;
  logic       rst = 1'b1;
  logic       src_valid = 1'b0;
  logic       src_stall;
  src_item_t  src_data = '0;
  logic       tok_valid;
  logic       tok_stall = 1'b0;
  tok_item_t  tok_data;

  keyword_number_lexer_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_data  (tok_data)
  );

  src_item_t src_backlog[$];
  tok_item_t pending_tokens[$];
  tok_item_t step_out[$];

  int  items_total = 0;
  int  items_sent = 0;
  int  items_taken = 0;
  int  phase_len = 0;
  int  sources = 0;
  int  tokens_checked = 0;
  int  errors_seen = 0;
  int  err_count = 0;
  logic src_taken = 1'b0;

  // Lexer state mirrored by the predictor
  scan_mode_t  lx_mode;
  logic [23:0] byte_pos;
  logic [23:0] cur_line;
  logic [23:0] tok_start;
  logic [15:0] tok_len;
  logic        saw_dot;
  logic [2:0]  kw_hits;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit word_char(logic [7:0] c);
    return is_letter(c) || is_numeral(c) || c == CH_UNDER;
  endfunction

  function automatic logic [23:0] bump24(logic [23:0] v);
    return (v == '1) ? v : v + 24'd1;
  endfunction

  function automatic logic [15:0] bump16(logic [15:0] v);
    return (v == '1) ? v : v + 16'd1;
  endfunction

  function automatic string kw_word(int k);
    string word;
    case (k)
      0: word = "slonik";
      1: word = "from";
      default: word = "kartohka";
    endcase
    return word;
  endfunction

  function automatic void reset_lexer();
    lx_mode   = MODE_IDLE;
    byte_pos  = '0;
    cur_line  = 24'd1;
    tok_start = '0;
    tok_len   = '0;
    saw_dot   = 1'b0;
    kw_hits   = 3'b111;
  endfunction

  function automatic void add_token(logic [2:0] kind, logic [1:0] err, logic [7:0] bad,
                                    logic [23:0] pos, logic [23:0] line, logic [15:0] len);
    tok_item_t t;
    if (step_out.size() < 3) begin
      t.token_kind   = kind;
      t.error_code   = err;
      t.bad_char     = bad;
      t.start_pos    = pos;
      t.line_number  = line;
      t.token_length = len;
      t.last_of_run  = 1'b0;
      step_out.insert(step_out.size(), t);
    end
  endfunction

  // Drop keyword candidates that no longer match at the current length
  function automatic void update_hits(logic [7:0] c);
    string word;
    for (int k = 0; k < 3; k++) begin
      word = kw_word(k);
      if (kw_hits[k] && !(tok_len < word.len() && word[tok_len] == c))
        kw_hits[k] = 1'b0;
    end
  endfunction

  function automatic void flush_token();
    logic [2:0] kind;
    string      word;
    case (lx_mode)
      MODE_IDENT: begin
        kind = KIND_IDENT;
        for (int k = 0; k < 3; k++) begin
          word = kw_word(k);
          if (kw_hits[k] && tok_len == word.len()) kind = KIND_SLONIK + 3'(k);
        end
        add_token(kind, ERR_NONE, 8'd0, tok_start, cur_line, tok_len);
      end
      MODE_NUM: begin
        add_token(saw_dot ? KIND_FLOAT : KIND_INT, ERR_NONE, 8'd0, tok_start, cur_line,
                  tok_len);
      end
      MODE_PCT: begin
        add_token(KIND_IDENT, ERR_UNKNOWN, CH_PERCENT, tok_start, cur_line, 16'd0);
      end
      MODE_GT: begin
        add_token(KIND_IDENT, ERR_UNKNOWN, CH_GT, tok_start, cur_line, 16'd0);
      end
      default: ;
    endcase
  endfunction

  // Byte seen with no token in progress
  function automatic void start_token(logic [7:0] c, logic [23:0] here);
    lx_mode = MODE_IDLE;
    if (c == CH_SPACE || c == CH_TAB) begin
    end else if (c == CH_NEWLINE) begin
      cur_line = bump24(cur_line);
    end else begin
      tok_start = here;
      if (c == CH_PERCENT) begin
        lx_mode = MODE_PCT;
      end else if (c == CH_GT) begin
        lx_mode = MODE_GT;
      end else if (is_letter(c) || c == CH_UNDER) begin
        tok_len = '0;
        kw_hits = 3'b111;
        update_hits(c);
        tok_len = 16'd1;
        lx_mode = MODE_IDENT;
      end else if (is_numeral(c)) begin
        tok_len = 16'd1;
        saw_dot = 1'b0;
        lx_mode = MODE_NUM;
      end else begin
        add_token(KIND_IDENT, ERR_UNKNOWN, c, here, cur_line, 16'd0);
        lx_mode = MODE_HALT;
      end
    end
  endfunction

  // Advance the predicted lexer by one source transaction
  function automatic void lex_item(src_item_t it);
    logic [7:0]  c;
    logic [23:0] here;
    tok_item_t   tail;
    c = it.char_byte;
    here = byte_pos;
    step_out.delete();
    if (it.has_byte) begin
      case (lx_mode)
        MODE_HALT: ;
        MODE_COMMENT: begin
          if (c == CH_NEWLINE) start_token(c, here);
        end
        MODE_PCT: begin
          if (c == CH_PERCENT) begin
            lx_mode = MODE_COMMENT;
          end else begin
            flush_token();
            lx_mode = MODE_HALT;
          end
        end
        MODE_GT: begin
          if (c == CH_GT) begin
            add_token(KIND_OUTPUT, ERR_NONE, 8'd0, tok_start, cur_line, 16'd2);
            lx_mode = MODE_IDLE;
          end else begin
            flush_token();
            lx_mode = MODE_HALT;
          end
        end
        MODE_IDENT: begin
          if (word_char(c)) begin
            update_hits(c);
            tok_len = bump16(tok_len);
          end else begin
            flush_token();
            start_token(c, here);
          end
        end
        MODE_NUM: begin
          if (is_numeral(c)) begin
            tok_len = bump16(tok_len);
          end else if (c == CH_DOT) begin
            if (saw_dot) begin
              add_token(KIND_IDENT, ERR_EXTRA_DOT, 8'd0, here, cur_line, 16'd0);
              lx_mode = MODE_HALT;
            end else begin
              saw_dot = 1'b1;
              tok_len = bump16(tok_len);
            end
          end else begin
            flush_token();
            start_token(c, here);
          end
        end
        default: start_token(c, here);
      endcase
      byte_pos = bump24(byte_pos);
    end
    if (it.end_of_source) begin
      flush_token();
      add_token(KIND_END, ERR_NONE, 8'd0, byte_pos, cur_line, 16'd0);
      reset_lexer();
    end
    if (step_out.size() > 0) begin
      tail = step_out.pop_back();
      tail.last_of_run = 1'b1;
      step_out.insert(step_out.size(), tail);
    end
    foreach (step_out[i]) pending_tokens.insert(pending_tokens.size(), step_out[i]);
  endfunction

  function automatic void cmp_field(string name, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  // ---------------- stimulus builders ----------------

  function automatic void push_byte(logic [7:0] c);
    src_item_t it;
    it.char_byte = c;
    it.has_byte = 1'b1;
    it.end_of_source = 1'b0;
    src_backlog.insert(src_backlog.size(), it);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  // Transaction with no byte; closes the source when eos is set
  function automatic void push_empty(bit eos);
    src_item_t it;
    it.char_byte = 8'($urandom_range(0, 255));
    it.has_byte = 1'b0;
    it.end_of_source = eos;
    src_backlog.insert(src_backlog.size(), it);
  endfunction

  function automatic void close_source(bit bare);
    src_item_t it;
    if (bare || src_backlog.size() == 0) begin
      push_empty(1'b1);
    end else begin
      it = src_backlog.pop_back();
      it.end_of_source = 1'b1;
      src_backlog.insert(src_backlog.size(), it);
    end
    sources++;
  endfunction

  function automatic logic [7:0] pick_word_char(bit head);
    int r;
    r = $urandom_range(0, head ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return CH_UNDER;
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_stray();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (word_char(c) || c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE ||
           c == CH_PERCENT || c == CH_GT);
    return c;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return CH_TAB;
      1: return CH_NEWLINE;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic void push_piece();
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0: push_text("slonik");
      1: push_text("from");
      2: push_text("kartohka");
      3: begin
        case ($urandom_range(0, 6))
          0: push_text("slon");
          1: push_text("fromm");
          2: push_text("kartohka_");
          3: push_text("Slonik");
          4: push_text("kartoh");
          5: push_text("fr0m");
          default: push_text("slonikk");
        endcase
      end
      4: begin
        push_byte(pick_word_char(1'b1));
        repeat ($urandom_range(0, 6)) push_byte(pick_word_char(1'b0));
      end
      5: repeat ($urandom_range(1, 5)) push_byte(pick_digit());
      6: begin
        repeat ($urandom_range(1, 3)) push_byte(pick_digit());
        push_byte(CH_DOT);
        repeat ($urandom_range(0, 3)) push_byte(pick_digit());
      end
      7: push_text(">>");
      8: begin
        push_text("%%");
        repeat ($urandom_range(0, 6)) begin
          do c = 8'($urandom_range(0, 255));
          while (c == CH_NEWLINE);
          push_byte(c);
        end
        push_byte(CH_NEWLINE);
      end
      default: repeat ($urandom_range(1, 3)) push_byte(pick_blank());
    endcase
  endfunction

  // Broken ending: the lexer halts here, so the bytes after it are noise, unless a lone % or > gets its pair
  function automatic void push_fault();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: begin
        push_byte(pick_digit());
        push_byte(CH_DOT);
        repeat ($urandom_range(0, 2)) push_byte(pick_digit());
        push_byte(CH_DOT);
      end
      1: begin
        push_byte(CH_PERCENT);
        if ($urandom_range(0, 2) != 0) begin
          do c = 8'($urandom_range(0, 255));
          while (c == CH_PERCENT);
          push_byte(c);
        end
      end
      2: begin
        push_byte(CH_GT);
        if ($urandom_range(0, 2) != 0) begin
          do c = 8'($urandom_range(0, 255));
          while (c == CH_GT);
          push_byte(c);
        end
      end
      default: push_byte(pick_stray());
    endcase
    repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic int idle_pct(bit sender);
    if (items_sent < phase_len) return sender ? 11 : 72;
    if (items_sent < 2 * phase_len) return sender ? 72 : 11;
    return 0;
  endfunction

  // ---------------- driver ----------------

  always @(negedge clk) begin
    if (!rst) begin
      tok_stall <= ($urandom_range(0, 99) < idle_pct(1'b0));
      if (!src_valid || src_taken) begin
        if (src_backlog.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          src_data <= src_backlog.pop_front();
          src_valid <= 1'b1;
          items_sent++;
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin : monitor
    tok_item_t want;
    if (rst) begin
      src_taken <= 1'b0;
    end else begin
      src_taken <= src_valid && !src_stall;
      if (tok_valid && !tok_stall) begin
        if (pending_tokens.size() == 0) begin
          $error("unexpected token transaction: kind %0d, error %0d, pos %0d",
                 tok_data.token_kind, tok_data.error_code, tok_data.start_pos);
          err_count++;
        end else begin
          want = pending_tokens.pop_front();
          cmp_field("token_kind", 24'(want.token_kind), 24'(tok_data.token_kind));
          cmp_field("error_code", 24'(want.error_code), 24'(tok_data.error_code));
          cmp_field("bad_char", 24'(want.bad_char), 24'(tok_data.bad_char));
          cmp_field("start_pos", want.start_pos, tok_data.start_pos);
          cmp_field("line_number", want.line_number, tok_data.line_number);
          cmp_field("token_length", 24'(want.token_length), 24'(tok_data.token_length));
          cmp_field("last_of_run", 24'(want.last_of_run), 24'(tok_data.last_of_run));
          tokens_checked++;
          if (want.error_code != ERR_NONE) errors_seen++;
        end
      end
      if (src_valid && !src_stall) begin
        lex_item(src_data);
        items_taken++;
      end
    end
  end

  // ---------------- stimulus and end of run ----------------

  initial begin
    reset_lexer();

    // keyword, float, output token, then end of source on the last byte
    push_text("from 1.5>>");
    close_source(1'b0);
    // comment, newline, underscore identifier, bare flush
    push_text("%%x");
    push_byte(CH_NEWLINE);
    push_text("_9");
    close_source(1'b1);
    // second dot
    push_text("1..");
    close_source(1'b0);
    // identifier, lone greater-than and end marker from one transaction
    push_text("x>");
    close_source(1'b0);
    // no-byte transaction, then a non-ASCII byte
    push_empty(1'b0);
    push_byte(8'hFF);
    close_source(1'b0);
    // lone percent followed by a letter
    push_text("%a");
    close_source(1'b1);

    while (src_backlog.size() < 290) begin
      repeat ($urandom_range(4, 14)) begin
        push_piece();
        if ($urandom_range(0, 9) < 7) push_byte(pick_blank());
        if ($urandom_range(0, 19) == 0) push_empty(1'b0);
      end
      if ($urandom_range(0, 4) == 0) push_fault();
      close_source($urandom_range(0, 2) == 0);
    end
    phase_len = src_backlog.size() / 3;
    items_total = src_backlog.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (items_taken != items_total || pending_tokens.size() != 0);
    repeat (10) @(negedge clk);

    $display("Lexed %0d sources, %0d source transactions, %0d tokens checked (%0d errors).",
             sources, items_taken, tokens_checked, errors_seen);
    $display("Included keyword near misses, comments, halts and bare end-of-source flushes.");
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout: %0d of %0d source transactions taken, %0d tokens still due",
             items_taken, items_total, pending_tokens.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* keyword_number_lexer_unit.f */
design/knl_pkg.sv
design/keyword_number_lexer_unit.sv
dv/tb_top.sv
